// File: rtl/i2cbe_pkg.sv
package i2cbe_pkg;

  localparam int unsigned DataBits = 8;
  localparam int unsigned CntW     = $clog2(DataBits);

  // command codes
  localparam logic [2:0] OpStart   = 3'd0;
  localparam logic [2:0] OpStop    = 3'd1;
  localparam logic [2:0] OpSend    = 3'd2;
  localparam logic [2:0] OpRecv    = 3'd3;
  localparam logic [2:0] OpSendAck = 3'd4;
  localparam logic [2:0] OpRecvAck = 3'd5;

  // per-step control from sequencer to shifter
  typedef struct packed {
    logic shift_tx;   // drop the bit just driven
    logic sample;     // take one SDA sample into the rx register
    logic rx_valid;   // show received byte on this result
    logic ack_valid;  // show sampled ack on this result
  } step_ctrl_t;

  // pin levels after a write, 1 = released
  typedef struct packed {
    logic scl;
    logic sda;
  } pins_t;

endpackage

// File: rtl/i2cbe_shift.sv
module i2cbe_shift (
  input  logic                             clk_i,
  input  logic                             load_i,
  input  logic [i2cbe_pkg::DataBits-1:0]   tx_byte_i,
  input  logic                             ack_out_i,
  input  logic [i2cbe_pkg::DataBits-1:0]   sda_samples_i,
  input  logic                             step_i,
  input  i2cbe_pkg::step_ctrl_t            ctrl_i,
  output logic                             tx_msb_o,
  output logic                             ack_out_o,
  output logic [i2cbe_pkg::DataBits-1:0]   rx_byte_o,
  output logic                             ack_in_o
);
  import i2cbe_pkg::*;

  logic [DataBits-1:0] tx_sr_q, tx_sr_d;
  logic [DataBits-1:0] smp_sr_q, smp_sr_d;
  logic [DataBits-1:0] rx_sr_q, rx_sr_d;
  logic                ack_q, ack_d;

  always_comb begin
    tx_sr_d  = tx_sr_q;
    smp_sr_d = smp_sr_q;
    rx_sr_d  = rx_sr_q;
    ack_d    = ack_q;
    if (load_i) begin
      tx_sr_d  = tx_byte_i;
      smp_sr_d = sda_samples_i;
      ack_d    = ack_out_i;
    end else if (step_i) begin
      if (ctrl_i.shift_tx) begin
        tx_sr_d = {tx_sr_q[DataBits-2:0], 1'b0};
      end
      if (ctrl_i.sample) begin
        rx_sr_d  = {rx_sr_q[DataBits-2:0], smp_sr_q[DataBits-1]};
        smp_sr_d = {smp_sr_q[DataBits-2:0], 1'b0};
      end
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    tx_sr_q  <= tx_sr_d;
    smp_sr_q <= smp_sr_d;
    rx_sr_q  <= rx_sr_d;
    ack_q    <= ack_d;
  end

  assign tx_msb_o  = tx_sr_q[DataBits-1];
  assign ack_out_o = ack_q;
  assign rx_byte_o = ctrl_i.rx_valid ? rx_sr_q : '0;
  assign ack_in_o  = ctrl_i.ack_valid & smp_sr_q[DataBits-1];

endmodule

// File: rtl/i2cbe_seq.sv
module i2cbe_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [2:0]             operation_i,
  input  logic                   step_i,
  input  logic                   tx_msb_i,
  input  logic                   ack_out_i,
  output logic                   busy_o,
  output logic                   last_o,
  output i2cbe_pkg::step_ctrl_t  ctrl_o,
  output i2cbe_pkg::pins_t       pins_o
);
  import i2cbe_pkg::*;

  logic            busy_q, busy_d;
  logic [2:0]      op_q, op_d;
  logic [1:0]      ph_q, ph_d;
  logic [CntW-1:0] bit_q, bit_d;
  pins_t           pins_q, pins_d;
  logic            last_bit;

  assign last_bit = (bit_q == CntW'(DataBits - 1));

  always_comb begin
    busy_d = busy_q;
    op_d   = op_q;
    ph_d   = ph_q;
    bit_d  = bit_q;
    pins_d = pins_q;
    last_o = 1'b0;
    ctrl_o = '0;

    if (accept_i) begin
      busy_d = (operation_i <= OpRecvAck);
      op_d   = operation_i;
      ph_d   = '0;
      bit_d  = '0;
    end else if (step_i) begin
      ph_d = ph_q + 2'd1;
      case (op_q)
        OpStart: begin
          case (ph_q)
            2'd0:    pins_d.sda = 1'b1;
            2'd1:    pins_d.scl = 1'b1;
            2'd2:    pins_d.sda = 1'b0;
            default: begin
              pins_d.scl = 1'b0;
              last_o     = 1'b1;
            end
          endcase
        end
        OpStop: begin
          case (ph_q)
            2'd0:    pins_d.sda = 1'b0;
            2'd1:    pins_d.scl = 1'b1;
            default: begin
              pins_d.sda = 1'b1;
              last_o     = 1'b1;
            end
          endcase
        end
        OpSend: begin
          case (ph_q)
            2'd0:    pins_d.sda = tx_msb_i;
            2'd1:    pins_d.scl = 1'b1;
            default: begin
              pins_d.scl      = 1'b0;
              ctrl_o.shift_tx = 1'b1;
              last_o          = last_bit;
              ph_d            = 2'd0;
              bit_d           = bit_q + 1'b1;
            end
          endcase
        end
        OpRecv: begin
          case (ph_q)
            2'd0:    pins_d.sda = 1'b1;
            2'd1: begin
              pins_d.scl    = 1'b1;
              ctrl_o.sample = 1'b1;
            end
            default: begin
              pins_d.scl      = 1'b0;
              ctrl_o.rx_valid = last_bit;
              last_o          = last_bit;
              ph_d            = 2'd1;
              bit_d           = bit_q + 1'b1;
            end
          endcase
        end
        OpSendAck: begin
          case (ph_q)
            2'd0:    pins_d.sda = ack_out_i;
            2'd1:    pins_d.scl = 1'b1;
            default: begin
              pins_d.scl = 1'b0;
              last_o     = 1'b1;
            end
          endcase
        end
        OpRecvAck: begin
          case (ph_q)
            2'd0:    pins_d.sda = 1'b1;
            2'd1:    pins_d.scl = 1'b1;
            default: begin
              pins_d.scl       = 1'b0;
              ctrl_o.ack_valid = 1'b1;
              last_o           = 1'b1;
            end
          endcase
        end
        default: last_o = 1'b1;
      endcase
      if (last_o) begin
        busy_d = 1'b0;
        bit_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      op_q   <= OpStart;
      ph_q   <= '0;
      bit_q  <= '0;
      pins_q <= '1;
    end else begin
      busy_q <= busy_d;
      op_q   <= op_d;
      ph_q   <= ph_d;
      bit_q  <= bit_d;
      pins_q <= pins_d;
    end
  end

  assign busy_o = busy_q;
  assign pins_o = pins_d;

endmodule

// File: rtl/i2c_master_bit_engine_core.sv
// Channel   Dir  Handshake                      Contents
// s_axis    in   s_axis_tvalid / s_axis_tready  one command per transaction
// m_axis    out  m_axis_tvalid / m_axis_tready  one pin write per transaction
//
// Pin writes per command: start 4, stop 3, send byte 24, receive byte 17,
// send/receive ack 3; they leave one per cycle while the sink keeps up.
// Unused codes are taken and produce nothing. The phase sequencer steps
// once per result; bits move through the shift registers at most one per
// step. A new command can be taken while the last write of the previous
// one is held in the output register.
// Reset: both lines released, engine idle. A stalled sink holds the output
// register and freezes the sequencer.
module i2c_master_bit_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] operation, [10:3] tx_byte, [11] ack_out, [19:12] sda_samples
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] scl_level, [1] sda_level, [9:2] rx_byte, [10] ack_in
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import i2cbe_pkg::*;

  logic                accept;
  logic                step;
  logic                busy;
  logic                last;
  step_ctrl_t          ctrl;
  pins_t               pins;
  logic                tx_msb;
  logic                ack_out;
  logic [DataBits-1:0] rx_byte;
  logic                ack_in;

  logic        m_valid_q, m_valid_d;
  logic [15:0] m_data_q, m_data_d;
  logic        m_last_q, m_last_d;

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  // one pin write per step, only when the output register can take it
  assign step          = busy && (!m_valid_q || m_axis_tready);

  i2cbe_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .operation_i(s_axis_tdata[2:0]),
    .step_i     (step),
    .tx_msb_i   (tx_msb),
    .ack_out_i  (ack_out),
    .busy_o     (busy),
    .last_o     (last),
    .ctrl_o     (ctrl),
    .pins_o     (pins)
  );

  i2cbe_shift u_shift (
    .clk_i        (clk_i),
    .load_i       (accept),
    .tx_byte_i    (s_axis_tdata[10:3]),
    .ack_out_i    (s_axis_tdata[11]),
    .sda_samples_i(s_axis_tdata[19:12]),
    .step_i       (step),
    .ctrl_i       (ctrl),
    .tx_msb_o     (tx_msb),
    .ack_out_o    (ack_out),
    .rx_byte_o    (rx_byte),
    .ack_in_o     (ack_in)
  );

  // output register
  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;
    if (step) begin
      m_valid_d = 1'b1;
      m_data_d  = {5'd0, ack_in, rx_byte, pins.sda, pins.scl};
      m_last_d  = last;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

`ifndef NO_ASSERTIONS
  // every command ends with SCL low, except stop which leaves both released
  a_last_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |->
      (!m_axis_tdata[0] || (m_axis_tdata[0] && m_axis_tdata[1])))
    else $error("command ended with SCL high and SDA low");

  // a legal command keeps the engine busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (s_axis_tdata[2:0] <= OpRecvAck)) |=> !s_axis_tready)
    else $error("legal command did not start the sequencer");

  // the final write of a command frees the input side
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && last) |=> (s_axis_tready && m_axis_tvalid && m_axis_tlast))
    else $error("engine still busy after final pin write");
`endif

endmodule

// File: tb/tb_i2c_master_bit_engine_core.sv
`timescale 1ns / 1ps

module tb_i2c_master_bit_engine_core;
  import i2cbe_pkg::*;

  // codes the engine takes and drops without a pin write
  localparam logic [2:0] OpRsvd6 = 3'd6;
  localparam logic [2:0] OpRsvd7 = 3'd7;

  localparam int WdLimit     = 5000;  // cycles with no transaction on either side
  localparam int HoldOff     = 300;   // long sink stall, fills the engine
  localparam int DrainCycles = 40;    // > longest command, covers dropped codes
  localparam int PhaseItems  = 45;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tx;
    logic       ack;
    logic [7:0] samples;
  } cmd_t;

  // one pin write as it leaves on m_axis
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] rx;
    logic       ack;
    logic       last;
  } pin_write_t;

  // stimulus row; when typed is set the last pin write is given here
  typedef struct packed {
    cmd_t       cmd;
    logic       typed;
    logic       scl;
    logic       sda;
    logic [7:0] rx;
    logic       ack;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  i2c_master_bit_engine_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  pin_write_t pin_writes_q[$];
  pins_t      bus_lvl = 2'b11;  // scl, sda released after reset
  int         mismatch_cnt = 0;
  int         valid_sent = 0;
  int         src_idle_pct = 0;
  int         sink_stall_pct = 0;
  int         hold_cycles = 0;

  // cmd fields: op, tx, ack, samples | typed, scl, sda, rx, ack_in
  dir_row_t dir_tbl [21] = '{
    '{'{OpStart,   8'h00, 1'b0, 8'h00}, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
    '{'{OpSend,    8'hFF, 1'b0, 8'h00}, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0},
    '{'{OpRecvAck, 8'h00, 1'b0, 8'h80}, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1},
    '{'{OpSend,    8'h00, 1'b1, 8'hFF}, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
    '{'{OpRecvAck, 8'hFF, 1'b1, 8'h7F}, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0},
    '{'{OpSend,    8'hA5, 1'b0, 8'h00}, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
    '{'{OpSendAck, 8'h00, 1'b0, 8'h00}, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
    '{'{OpRecv,    8'h00, 1'b0, 8'hFF}, 1'b1, 1'b0, 1'b1, 8'hFF, 1'b0},
    '{'{OpSendAck, 8'hFF, 1'b1, 8'hFF}, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0},
    '{'{OpRecv,    8'hFF, 1'b1, 8'h00}, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0},
    '{'{OpRecv,    8'h00, 1'b0, 8'h5A}, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
    '{'{OpSendAck, 8'h00, 1'b1, 8'h00}, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
    '{'{OpRsvd6,   8'hFF, 1'b1, 8'hFF}, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
    '{'{OpRsvd7,   8'h00, 1'b0, 8'h00}, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
    '{'{OpStop,    8'h00, 1'b0, 8'h00}, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0},
    '{'{OpStop,    8'hFF, 1'b1, 8'hFF}, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0},
    '{'{OpStart,   8'hFF, 1'b1, 8'hFF}, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
    '{'{OpRecvAck, 8'h00, 1'b0, 8'hFF}, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1},
    '{'{OpSend,    8'h3C, 1'b1, 8'hFF}, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
    '{'{OpRsvd7,   8'hFF, 1'b1, 8'hFF}, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
    '{'{OpStop,    8'h00, 1'b0, 8'h00}, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0}
  };

  // ---------------------------------------------------------------- predictor
  task automatic set_sda_lvl(input logic v, input logic [7:0] rx, input logic ack,
                             input logic fin);
    bus_lvl.sda = v;
    pin_writes_q.push_back(pin_write_t'{bus_lvl.scl, bus_lvl.sda, rx, ack, fin});
  endtask

  task automatic set_scl_lvl(input logic v, input logic [7:0] rx, input logic ack,
                             input logic fin);
    bus_lvl.scl = v;
    pin_writes_q.push_back(pin_write_t'{bus_lvl.scl, bus_lvl.sda, rx, ack, fin});
  endtask

  task automatic predict_pin_writes(input cmd_t c);
    logic [7:0] rx_acc;
    logic       fin;
    rx_acc = '0;
    case (c.op)
      OpStart: begin
        set_sda_lvl(1'b1, 8'h00, 1'b0, 1'b0);
        set_scl_lvl(1'b1, 8'h00, 1'b0, 1'b0);
        set_sda_lvl(1'b0, 8'h00, 1'b0, 1'b0);
        set_scl_lvl(1'b0, 8'h00, 1'b0, 1'b1);
      end
      OpStop: begin
        set_sda_lvl(1'b0, 8'h00, 1'b0, 1'b0);
        set_scl_lvl(1'b1, 8'h00, 1'b0, 1'b0);
        set_sda_lvl(1'b1, 8'h00, 1'b0, 1'b1);
      end
      OpSend: begin
        for (int i = 0; i < DataBits; i++) begin
          fin = (i == DataBits - 1);
          set_sda_lvl(c.tx[DataBits-1-i], 8'h00, 1'b0, 1'b0);
          set_scl_lvl(1'b1, 8'h00, 1'b0, 1'b0);
          set_scl_lvl(1'b0, 8'h00, 1'b0, fin);
        end
      end
      OpRecv: begin
        set_sda_lvl(1'b1, 8'h00, 1'b0, 1'b0);
        for (int i = 0; i < DataBits; i++) begin
          fin = (i == DataBits - 1);
          set_scl_lvl(1'b1, 8'h00, 1'b0, 1'b0);
          rx_acc[DataBits-1-i] = c.samples[DataBits-1-i];
          set_scl_lvl(1'b0, fin ? rx_acc : 8'h00, 1'b0, fin);
        end
      end
      OpSendAck: begin
        set_sda_lvl(c.ack, 8'h00, 1'b0, 1'b0);
        set_scl_lvl(1'b1, 8'h00, 1'b0, 1'b0);
        set_scl_lvl(1'b0, 8'h00, 1'b0, 1'b1);
      end
      OpRecvAck: begin
        set_sda_lvl(1'b1, 8'h00, 1'b0, 1'b0);
        set_scl_lvl(1'b1, 8'h00, 1'b0, 1'b0);
        set_scl_lvl(1'b0, 8'h00, c.samples[7], 1'b1);
      end
      default: ;  // dropped code: no pin write, pins unchanged
    endcase
  endtask

  // ------------------------------------------------------------------ driving
  // Leaves tvalid high after the transaction so that a back-to-back command
  // keeps it up; callers lower it before any wait of their own.
  task automatic send_cmd(input dir_row_t row);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, row.cmd.samples, row.cmd.ack, row.cmd.tx, row.cmd.op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_pin_writes(row.cmd);
    if (row.typed)
      pin_writes_q[pin_writes_q.size()-1] =
        pin_write_t'{row.scl, row.sda, row.rx, row.ack, 1'b1};
    if (row.cmd.op <= OpRecvAck) valid_sent++;
  endtask

  function automatic dir_row_t rand_row(input logic [2:0] op);
    dir_row_t r;
    r = '0;
    r.cmd.op      = op;
    r.cmd.tx      = 8'($urandom);
    r.cmd.ack     = 1'($urandom);
    r.cmd.samples = 8'($urandom);
    return r;
  endfunction

  // One bus transfer: start, address, ack, one to four data bytes in one
  // direction, usually a stop; a missing stop gives a repeated start. Now
  // and then random commands are thrown in, dropped codes among them.
  task automatic run_frame();
    int  n_data;
    bit  rd;
    int  n_noise;
    n_data = $urandom_range(4, 1);
    rd     = 1'($urandom);
    if ($urandom_range(3) == 0) begin
      n_noise = $urandom_range(3, 1);
      repeat (n_noise) send_cmd(rand_row(3'($urandom_range(7))));
    end
    send_cmd(rand_row(OpStart));
    send_cmd(rand_row(OpSend));
    send_cmd(rand_row(OpRecvAck));
    repeat (n_data) begin
      if (rd) begin
        send_cmd(rand_row(OpRecv));
        send_cmd(rand_row(OpSendAck));
      end else begin
        send_cmd(rand_row(OpSend));
        send_cmd(rand_row(OpRecvAck));
      end
    end
    if ($urandom_range(3) != 0) send_cmd(rand_row(OpStop));
  endtask

  // sender stops until every pin write has come back, plus room for a
  // dropped code still in flight
  task automatic drain_writes();
    s_axis_tvalid <= 1'b0;
    while (pin_writes_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // sink side: random stalls, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // ----------------------------------------------------------------- checking
  task automatic cmp_field(input string name, input logic [7:0] exp_v,
                           input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : chk_pins
    pin_write_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pin_writes_q.size() == 0) begin
        $error("pin write with none expected: tdata %0h", m_axis_tdata);
        mismatch_cnt++;
      end else begin
        w = pin_writes_q.pop_front();
        cmp_field("scl_level", 8'(w.scl),  8'(m_axis_tdata[0]));
        cmp_field("sda_level", 8'(w.sda),  8'(m_axis_tdata[1]));
        cmp_field("rx_byte",   w.rx,       m_axis_tdata[9:2]);
        cmp_field("ack_in",    8'(w.ack),  8'(m_axis_tdata[10]));
        cmp_field("last",      8'(w.last), 8'(m_axis_tlast));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WdLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[i2c_master_bit_engine_core] ERROR");
    $finish;
  end

  // -------------------------------------------------------------------- main
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) send_cmd(dir_tbl[i]);
    drain_writes();

    // phases: no idling after a long sink hold-off, sender idle, sink stalling, both
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  hold_cycles = HoldOff; end
        1: begin src_idle_pct = 72; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 72; end
        default: begin src_idle_pct = 18; sink_stall_pct = 18; end
      endcase
      valid_sent = 0;
      while (valid_sent < PhaseItems) run_frame();
      drain_writes();
    end

    if (mismatch_cnt == 0) begin
      $display("[i2c_master_bit_engine_core] OK");
    end else begin
      $display("[i2c_master_bit_engine_core] ERROR");
    end
    $finish;
  end

endmodule
